// ----- rtl/core/masked_pixel_bias_stats_defines.svh -----
// assertion macros for the masked pixel bias statistics block
// used by the checker only, no other dependencies
`ifndef MASKED_PIXEL_BIAS_STATS_DEFINES_SVH
`define MASKED_PIXEL_BIAS_STATS_DEFINES_SVH

// same-cycle implication, ignored while reset is held
`define MPBS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mpbs check failed");

// next-cycle implication, ignored while reset is held
`define MPBS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mpbs check failed");

`endif

// ----- rtl/core/mpbs_pkg.sv -----
// shared types, constants and arithmetic helpers for the masked pixel bias statistics block
// no dependencies
package mpbs_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COORD_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH     = 2;
    localparam int CFG_IDX_BITS    = 8;
    localparam int CFG_DATA_BITS   = 64;
    // compare width wide enough for sample widths up to 33 bits and the 16 bit bounds
    localparam int CMP_BITS        = 33;

    localparam logic [CFG_IDX_BITS-1:0] REG_IN_VALID  = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_REF_VALID = 8'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_IN_GO     = 8'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_REF_GO    = 8'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW    = 8'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_MASK_A    = 8'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_MASK_B    = 8'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_FILL      = 8'd7;

    localparam logic [2:0] OP_LT = 3'd0;
    localparam logic [2:0] OP_GT = 3'd1;
    localparam logic [2:0] OP_LE = 3'd2;
    localparam logic [2:0] OP_GE = 3'd3;
    localparam logic [2:0] OP_EQ = 3'd4;
    localparam logic [2:0] OP_NE = 3'd5;

    localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;
    localparam logic [62:0] U63_MAX = {63{1'b1}};

    typedef struct packed {
        logic signed [15:0] in_gain;
        logic signed [31:0] in_ofs;
        logic signed [15:0] ref_gain;
        logic signed [31:0] ref_ofs;
        logic signed [31:0] fill;
    } t_back_cfg;

    typedef struct packed {
        logic signed [31:0] bias_out;
        logic               matched;
        logic [31:0]        match_total;
        logic signed [63:0] bias_total;
        logic [62:0]        abs_bias_total;
        logic [62:0]        sq_bias_total;
        logic signed [63:0] in_total;
        logic signed [63:0] ref_total;
        logic signed [63:0] cross_total;
        logic [62:0]        in_sq_total;
        logic signed [31:0] bias_lowest;
        logic signed [31:0] bias_highest;
    } t_result;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sh0_7FFF_FFFF) begin
            r = S32_MAX;
        end else if (v < -66'sh0_8000_0000) begin
            r = S32_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [64:0] s;
        logic signed [63:0] r;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63]) begin
            r = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            r = s[63:0];
        end
        return r;
    endfunction

    function automatic logic [62:0] uadd63(input logic [62:0] a, input logic [62:0] b);
        logic [63:0] s;
        s = 64'(a) + 64'(b);
        return s[63] ? U63_MAX : s[62:0];
    endfunction

    // unknown operators pass, a disabled mask passes
    function automatic logic mask_pass(input logic [19:0] setup,
                                       input logic signed [CMP_BITS-1:0] smp);
        logic signed [CMP_BITS-1:0] th;
        logic r;
        th = CMP_BITS'($signed(setup[19:4]));
        r  = 1'b1;
        if (setup[0]) begin
            unique case (setup[3:1])
                OP_LT:   r = smp < th;
                OP_GT:   r = smp > th;
                OP_LE:   r = smp <= th;
                OP_GE:   r = smp >= th;
                OP_EQ:   r = smp == th;
                OP_NE:   r = smp != th;
                default: r = 1'b1;
            endcase
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/masked_pixel_bias_stats.sv -----
// Masked pixel bias statistics, top level.
// Input queue side: drive the pixel fields with i_push; a transfer happens when i_push is
// high and o_full is low. The front classifies the pixel (window, valid ranges, two masks)
// in the cycle of the transfer and stores it in a two-entry item queue.
// Result queue side: while o_empty is low the oldest result sits on the o_ ports and
// moves on a transfer with i_pop high. A two-entry result queue decouples the back part
// from a stalled receiver; when the item queue fills, o_full rises and input waits.
// The back part runs one pixel at a time through a single shared multiplier: a matched
// pixel steps through the gain products, input square, cross product, bias square and
// queue write; an unmatched pixel goes straight to the queue write.
// Configuration: i_cfg_valid with o_cfg_ready (always high), register index and data;
// write only while no pixel is in flight. Indexes past the last register are dropped.
// Reset (i_rst_n low, synchronous) empties both queues, loads the register defaults and
// clears the statistics; start_image on a pixel clears them again before that pixel.
module masked_pixel_bias_stats #(
    parameter int SAMPLE_BITS = mpbs_pkg::SAMPLE_BITS_DEF,
    parameter int COORD_BITS  = mpbs_pkg::COORD_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mpbs_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [mpbs_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                               i_push,
    output logic                               o_full,
    input  logic [COORD_BITS-1:0]              i_pixel_x,
    input  logic [COORD_BITS-1:0]              i_pixel_y,
    input  logic signed [SAMPLE_BITS-1:0]      i_in_sample,
    input  logic signed [SAMPLE_BITS-1:0]      i_ref_sample,
    input  logic signed [SAMPLE_BITS-1:0]      i_mask_a_sample,
    input  logic signed [SAMPLE_BITS-1:0]      i_mask_b_sample,
    input  logic                               i_start_image,
    input  logic                               i_pop,
    output logic                               o_empty,
    output logic signed [31:0]                 o_bias_out,
    output logic                               o_matched,
    output logic [31:0]                        o_match_total,
    output logic signed [63:0]                 o_bias_total,
    output logic [62:0]                        o_abs_bias_total,
    output logic [62:0]                        o_sq_bias_total,
    output logic signed [63:0]                 o_in_total,
    output logic signed [63:0]                 o_ref_total,
    output logic signed [63:0]                 o_cross_total,
    output logic [62:0]                        o_in_sq_total,
    output logic signed [31:0]                 o_bias_lowest,
    output logic signed [31:0]                 o_bias_highest
);
    import mpbs_pkg::*;

    localparam int ITEM_W = 2 * SAMPLE_BITS + 2;

    logic [ITEM_W-1:0] item_wr, item_rd;
    logic              item_empty, item_pop;
    t_back_cfg         back_cfg;
    t_result           res_wr, res_rd;
    logic              res_push, res_full;

    assign o_cfg_ready = 1'b1;

    mpbs_front #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .i_in_sample    (i_in_sample),
        .i_ref_sample   (i_ref_sample),
        .i_mask_a_sample(i_mask_a_sample),
        .i_mask_b_sample(i_mask_b_sample),
        .i_start_image  (i_start_image),
        .o_item         (item_wr),
        .o_back_cfg     (back_cfg)
    );

    mpbs_fifo #(
        .W    (ITEM_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_item_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (i_push),
        .i_wr_data(item_wr),
        .o_full   (o_full),
        .i_rd     (item_pop),
        .o_rd_data(item_rd),
        .o_empty  (item_empty)
    );

    mpbs_back #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (back_cfg),
        .i_item       (item_rd),
        .i_item_empty (item_empty),
        .o_item_pop   (item_pop),
        .o_result     (res_wr),
        .o_result_push(res_push),
        .i_result_full(res_full)
    );

    mpbs_fifo #(
        .W    ($bits(t_result)),
        .DEPTH(QUEUE_DEPTH)
    ) u_res_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (res_push),
        .i_wr_data(res_wr),
        .o_full   (res_full),
        .i_rd     (i_pop),
        .o_rd_data(res_rd),
        .o_empty  (o_empty)
    );

    assign o_bias_out       = res_rd.bias_out;
    assign o_matched        = res_rd.matched;
    assign o_match_total    = res_rd.match_total;
    assign o_bias_total     = res_rd.bias_total;
    assign o_abs_bias_total = res_rd.abs_bias_total;
    assign o_sq_bias_total  = res_rd.sq_bias_total;
    assign o_in_total       = res_rd.in_total;
    assign o_ref_total      = res_rd.ref_total;
    assign o_cross_total    = res_rd.cross_total;
    assign o_in_sq_total    = res_rd.in_sq_total;
    assign o_bias_lowest    = res_rd.bias_lowest;
    assign o_bias_highest   = res_rd.bias_highest;

endmodule

// ----- rtl/core/mpbs_fifo.sv -----
// small register queue used between the front, the back and the result port
// depends on mpbs_pkg for the default depth
module mpbs_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = mpbs_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_wr,
    input  logic [W-1:0] i_wr_data,
    output logic         o_full,
    input  logic         i_rd,
    output logic [W-1:0] o_rd_data,
    output logic         o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp, n_wp, r_rp, n_rp;
    logic [NW-1:0] r_cnt, n_cnt;
    logic          wr_go, rd_go;

    assign o_full    = (r_cnt == NW'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign o_rd_data = r_mem[r_rp];
    assign wr_go     = i_wr && !o_full;
    assign rd_go     = i_rd && !o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (wr_go) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (rd_go) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (wr_go && !rd_go) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd_go && !wr_go) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_go) begin
            r_mem[r_wp] <= i_wr_data;
        end
    end

endmodule

// ----- rtl/core/mpbs_front.sv -----
// front part: configuration registers and per-pixel classification
// depends on mpbs_pkg; feeds the item queue and hands scaling setup to the back part
module mpbs_front #(
    parameter int SAMPLE_BITS = mpbs_pkg::SAMPLE_BITS_DEF,
    parameter int COORD_BITS  = mpbs_pkg::COORD_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic [mpbs_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [mpbs_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic [COORD_BITS-1:0]                i_pixel_x,
    input  logic [COORD_BITS-1:0]                i_pixel_y,
    input  logic signed [SAMPLE_BITS-1:0]        i_in_sample,
    input  logic signed [SAMPLE_BITS-1:0]        i_ref_sample,
    input  logic signed [SAMPLE_BITS-1:0]        i_mask_a_sample,
    input  logic signed [SAMPLE_BITS-1:0]        i_mask_b_sample,
    input  logic                                 i_start_image,
    output logic [2*SAMPLE_BITS+1:0]             o_item,
    output mpbs_pkg::t_back_cfg                  o_back_cfg
);
    import mpbs_pkg::*;

    logic [31:0] r_in_valid, r_ref_valid, r_fill;
    logic [47:0] r_in_go, r_ref_go;
    logic [63:0] r_window;
    logic [19:0] r_mask_a, r_mask_b;

    logic [15:0] px, py;
    logic signed [CMP_BITS-1:0] is_w, rs_w, ma_w, mb_w;
    logic in_window, in_ok, ref_ok, ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 32'h7FFF_8000;
            r_ref_valid <= 32'h7FFF_8000;
            r_in_go     <= 48'd4096;
            r_ref_go    <= 48'd4096;
            r_window    <= 64'hFFFF_FFFF_0000_FFFF;
            r_mask_a    <= '0;
            r_mask_b    <= '0;
            r_fill      <= '0;
        end else if (i_cfg_valid) begin
            // indexes past the list are dropped
            if (i_cfg_index == REG_IN_VALID)  r_in_valid  <= i_cfg_data[31:0];
            if (i_cfg_index == REG_REF_VALID) r_ref_valid <= i_cfg_data[31:0];
            if (i_cfg_index == REG_IN_GO)     r_in_go     <= i_cfg_data[47:0];
            if (i_cfg_index == REG_REF_GO)    r_ref_go    <= i_cfg_data[47:0];
            if (i_cfg_index == REG_WINDOW)    r_window    <= i_cfg_data;
            if (i_cfg_index == REG_MASK_A)    r_mask_a    <= i_cfg_data[19:0];
            if (i_cfg_index == REG_MASK_B)    r_mask_b    <= i_cfg_data[19:0];
            if (i_cfg_index == REG_FILL)      r_fill      <= i_cfg_data[31:0];
        end
    end

    assign px   = 16'(i_pixel_x);
    assign py   = 16'(i_pixel_y);
    assign is_w = CMP_BITS'(i_in_sample);
    assign rs_w = CMP_BITS'(i_ref_sample);
    assign ma_w = CMP_BITS'(i_mask_a_sample);
    assign mb_w = CMP_BITS'(i_mask_b_sample);

    assign in_window = (px >= r_window[15:0])  && (px <= r_window[31:16]) &&
                       (py >= r_window[47:32]) && (py <= r_window[63:48]);
    assign in_ok  = (is_w >= CMP_BITS'($signed(r_in_valid[15:0]))) &&
                    (is_w <= CMP_BITS'($signed(r_in_valid[31:16])));
    assign ref_ok = (rs_w >= CMP_BITS'($signed(r_ref_valid[15:0]))) &&
                    (rs_w <= CMP_BITS'($signed(r_ref_valid[31:16])));
    assign ok     = in_window && in_ok && ref_ok &&
                    mask_pass(r_mask_a, ma_w) && mask_pass(r_mask_b, mb_w);

    assign o_item = {i_start_image, ok, i_ref_sample, i_in_sample};

    assign o_back_cfg.in_gain  = r_in_go[15:0];
    assign o_back_cfg.in_ofs   = r_in_go[47:16];
    assign o_back_cfg.ref_gain = r_ref_go[15:0];
    assign o_back_cfg.ref_ofs  = r_ref_go[47:16];
    assign o_back_cfg.fill     = r_fill;

endmodule

// ----- rtl/core/mpbs_back.sv -----
// back part: shared multiplier sequencer, bias and saturating statistics
// depends on mpbs_pkg; reads the item queue and writes the result queue
module mpbs_back #(
    parameter int SAMPLE_BITS = mpbs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mpbs_pkg::t_back_cfg        i_cfg,
    input  logic [2*SAMPLE_BITS+1:0]   i_item,
    input  logic                       i_item_empty,
    output logic                       o_item_pop,
    output mpbs_pkg::t_result          o_result,
    output logic                       o_result_push,
    input  logic                       i_result_full
);
    import mpbs_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MI   = 8'b0000_0010,
        S_MR   = 8'b0000_0100,
        S_RV   = 8'b0000_1000,
        S_BI   = 8'b0001_0000,
        S_CR   = 8'b0010_0000,
        S_SQ   = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic signed [SAMPLE_BITS-1:0] r_is, r_rs;
    logic                          r_ok;
    logic signed [32:0]            mul_a, mul_b;
    logic signed [65:0]            r_prod;
    logic signed [31:0]            r_iv, r_rv, r_b, n_b;
    logic [31:0]                   r_ab, n_ab;
    logic signed [32:0]            neg_b;

    logic [31:0]        r_cnt;
    logic signed [63:0] r_bias_acc, r_in_acc, r_ref_acc, r_cross_acc;
    logic [62:0]        r_abs_acc, r_sq_acc, r_in_sq_acc;
    logic signed [31:0] r_min, r_max;

    logic item_start, item_ok;

    assign item_start = i_item[2*SAMPLE_BITS+1];
    assign item_ok    = i_item[2*SAMPLE_BITS];

    // one multiplier, operands picked by the step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_MI: begin
                mul_a = 33'(i_cfg.in_gain);
                mul_b = 33'(r_is);
            end
            S_MR: begin
                mul_a = 33'(i_cfg.ref_gain);
                mul_b = 33'(r_rs);
            end
            S_RV: begin
                mul_a = 33'(r_iv);
                mul_b = 33'(r_iv);
            end
            S_BI: begin
                mul_a = 33'(r_iv);
                mul_b = 33'(r_rv);
            end
            S_CR: begin
                mul_a = $signed({1'b0, r_ab});
                mul_b = $signed({1'b0, r_ab});
            end
            S_IDLE, S_SQ, S_OUT: begin
                mul_a = '0;
                mul_b = '0;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign n_b   = sat32(66'(r_iv) - 66'(r_rv));
    assign neg_b = -33'(n_b);
    assign n_ab  = n_b[31] ? neg_b[31:0] : n_b;

    assign o_item_pop    = (r_state == S_IDLE) && !i_item_empty;
    assign o_result_push = (r_state == S_OUT) && !i_result_full;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (!i_item_empty) n_state = item_ok ? S_MI : S_OUT;
            S_MI:    n_state = S_MR;
            S_MR:    n_state = S_RV;
            S_RV:    n_state = S_BI;
            S_BI:    n_state = S_CR;
            S_CR:    n_state = S_SQ;
            S_SQ:    n_state = S_OUT;
            S_OUT:   if (!i_result_full) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (o_item_pop) begin
            r_is <= i_item[SAMPLE_BITS-1:0];
            r_rs <= i_item[2*SAMPLE_BITS-1:SAMPLE_BITS];
            r_ok <= item_ok;
        end
        if (r_state == S_MR) r_iv <= sat32(r_prod + 66'(i_cfg.in_ofs));
        if (r_state == S_RV) r_rv <= sat32(r_prod + 66'(i_cfg.ref_ofs));
        if (r_state == S_BI) begin
            r_b  <= n_b;
            r_ab <= n_ab;
        end
    end

    // running statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (o_item_pop && item_start)) begin
            r_cnt       <= '0;
            r_bias_acc  <= '0;
            r_abs_acc   <= '0;
            r_sq_acc    <= '0;
            r_in_acc    <= '0;
            r_ref_acc   <= '0;
            r_cross_acc <= '0;
            r_in_sq_acc <= '0;
            r_min       <= S32_MAX;
            r_max       <= S32_MIN;
        end else begin
            if (r_state == S_BI) r_in_sq_acc <= uadd63(r_in_sq_acc, r_prod[62:0]);
            if (r_state == S_CR) begin
                r_cross_acc <= sadd64(r_cross_acc, r_prod[63:0]);
                if (r_cnt != '1) r_cnt <= r_cnt + 1'b1;
                r_bias_acc <= sadd64(r_bias_acc, 64'(r_b));
                r_abs_acc  <= uadd63(r_abs_acc, 63'(r_ab));
                r_in_acc   <= sadd64(r_in_acc, 64'(r_iv));
                r_ref_acc  <= sadd64(r_ref_acc, 64'(r_rv));
                if (r_b < r_min) r_min <= r_b;
                if (r_b > r_max) r_max <= r_b;
            end
            if (r_state == S_SQ) r_sq_acc <= uadd63(r_sq_acc, r_prod[62:0]);
        end
    end

    assign o_result.bias_out       = r_ok ? r_b : i_cfg.fill;
    assign o_result.matched        = r_ok;
    assign o_result.match_total    = r_cnt;
    assign o_result.bias_total     = r_bias_acc;
    assign o_result.abs_bias_total = r_abs_acc;
    assign o_result.sq_bias_total  = r_sq_acc;
    assign o_result.in_total       = r_in_acc;
    assign o_result.ref_total      = r_ref_acc;
    assign o_result.cross_total    = r_cross_acc;
    assign o_result.in_sq_total    = r_in_sq_acc;
    assign o_result.bias_lowest    = r_min;
    assign o_result.bias_highest   = r_max;

endmodule

// ----- rtl/core/mpbs_checker.sv -----
// port-level checker for the masked pixel bias statistics block, with its bind
// depends on masked_pixel_bias_stats_defines.svh
module mpbs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_pop,
    input logic               o_empty,
    input logic signed [31:0] o_bias_out,
    input logic               o_matched,
    input logic [31:0]        o_match_total,
    input logic signed [63:0] o_bias_total,
    input logic [62:0]        o_abs_bias_total,
    input logic [62:0]        o_sq_bias_total,
    input logic signed [31:0] o_bias_lowest,
    input logic signed [31:0] o_bias_highest
);
`include "masked_pixel_bias_stats_defines.svh"

    // a waiting result stays until it is taken
    `MPBS_ASSERT_NEXT(a_hold, !o_empty && !i_pop, !o_empty && $stable(o_bias_out))

    // a matched pixel always shows a non-zero count
    `MPBS_ASSERT_NOW(a_match_count, !o_empty && o_matched, o_match_total != 32'd0)

    // with no match yet the extremes keep their cleared values
    `MPBS_ASSERT_NOW(a_no_match_extremes, !o_empty && o_match_total == 32'd0,
        o_bias_lowest == 32'sh7FFF_FFFF && o_bias_highest == 32'sh8000_0000)

    // with no match yet the sums are still zero
    `MPBS_ASSERT_NOW(a_no_match_sums, !o_empty && o_match_total == 32'd0,
        o_bias_total == 64'sd0 && o_abs_bias_total == 63'd0 && o_sq_bias_total == 63'd0)

endmodule

bind masked_pixel_bias_stats mpbs_checker u_mpbs_checker (.*);

// ----- tb/masked_pixel_bias_stats_test.sv -----
// self-checking bench for masked_pixel_bias_stats: directed rows then randomised phases
// depends on mpbs_pkg and the masked_pixel_bias_stats rtl; predicts every result itself
module masked_pixel_bias_stats_test;
    import mpbs_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int RAND_PHASES = 13;
    localparam int PHASE_ITEMS = 150;
    localparam int HOLD_PHASE  = 3;
    localparam int LONG_HOLD   = 400;
    localparam logic [CFG_IDX_BITS-1:0] REG_NONE = 8'd200;
    localparam logic [CFG_IDX_BITS-1:0] REG_ID [8] = '{REG_IN_VALID, REG_REF_VALID,
        REG_IN_GO, REG_REF_GO, REG_WINDOW, REG_MASK_A, REG_MASK_B, REG_FILL};
    localparam logic [63:0] REG_KEEP [8] = '{64'hFFFF_FFFF, 64'hFFFF_FFFF,
        64'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF, '1, 64'hF_FFFF, 64'hF_FFFF, 64'hFFFF_FFFF};
    localparam t_result IDLE_RESULT = '{32'sd0, 1'b0, 32'd0, 64'sd0, 63'd0, 63'd0,
        64'sd0, 64'sd0, 64'sd0, 63'd0, S32_MAX, S32_MIN};

    typedef struct {
        logic [15:0]        x;
        logic [15:0]        y;
        logic signed [15:0] in_s;
        logic signed [15:0] ref_s;
        logic signed [15:0] ma;
        logic signed [15:0] mb;
        logic               start;
        int                 phase;
        bit                 fixed;
        t_result            fixed_res;
    } t_pixel_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;
    logic i_push;
    logic o_full;
    logic [15:0] i_pixel_x, i_pixel_y;
    logic signed [15:0] i_in_sample, i_ref_sample, i_mask_a_sample, i_mask_b_sample;
    logic i_start_image;
    logic i_pop;
    logic o_empty;
    t_result got;

    masked_pixel_bias_stats uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_push(i_push), .o_full(o_full),
        .i_pixel_x(i_pixel_x), .i_pixel_y(i_pixel_y),
        .i_in_sample(i_in_sample), .i_ref_sample(i_ref_sample),
        .i_mask_a_sample(i_mask_a_sample), .i_mask_b_sample(i_mask_b_sample),
        .i_start_image(i_start_image),
        .i_pop(i_pop), .o_empty(o_empty),
        .o_bias_out(got.bias_out), .o_matched(got.matched),
        .o_match_total(got.match_total), .o_bias_total(got.bias_total),
        .o_abs_bias_total(got.abs_bias_total), .o_sq_bias_total(got.sq_bias_total),
        .o_in_total(got.in_total), .o_ref_total(got.ref_total),
        .o_cross_total(got.cross_total), .o_in_sq_total(got.in_sq_total),
        .o_bias_lowest(got.bias_lowest), .o_bias_highest(got.bias_highest)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor copy of the registers and the running statistics
    logic [63:0] shadow_reg [8];
    logic [31:0] st_count;
    longint      st_bias, st_in, st_ref, st_cross;
    logic [62:0] st_abs, st_sq, st_in_sq;
    logic signed [31:0] st_low, st_high;

    t_result predicted_stats [$];
    int  fail_count = 0;
    int  cycles = 0;
    bit  long_hold_req = 0;
    int  rx_stall_pct = 15;
    bit  tx_no_gaps = 0;
    int  rx_hold_left = 0;
    logic [63:0] next_cfg [8];
    t_pixel_row dir_rows [$];

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** masked_pixel_bias_stats: FAILED **");
            $finish;
        end
    end

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sh7FFF_FFFF) return S32_MAX;
        if (v < -64'sh8000_0000) return S32_MIN;
        return v[31:0];
    endfunction

    function automatic longint acc_signed(longint a, longint b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        return s[63:0];
    endfunction

    function automatic logic [62:0] acc_unsigned(logic [62:0] a, logic [62:0] b);
        logic [63:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[63] ? {63{1'b1}} : s[62:0];
    endfunction

    function automatic bit mask_passes(logic [63:0] setup, logic signed [15:0] smp);
        logic signed [15:0] th;
        th = setup[19:4];
        if (!setup[0]) return 1'b1;
        case (setup[3:1])
            OP_LT:   return smp < th;
            OP_GT:   return smp > th;
            OP_LE:   return smp <= th;
            OP_GE:   return smp >= th;
            OP_EQ:   return smp == th;
            OP_NE:   return smp != th;
            default: return 1'b1;
        endcase
    endfunction

    function automatic logic signed [31:0] scaled(logic [63:0] go, logic signed [15:0] smp);
        longint g, o;
        g = $signed(go[15:0]);
        o = $signed(go[47:16]);
        return clamp32(g * longint'(smp) + o);
    endfunction

    task automatic clear_stats();
        st_count = 0;
        st_bias = 0; st_in = 0; st_ref = 0; st_cross = 0;
        st_abs = 0; st_sq = 0; st_in_sq = 0;
        st_low = S32_MAX;
        st_high = S32_MIN;
    endtask

    task automatic add_row(input t_pixel_row row);
        dir_rows = {dir_rows, row};
    endtask

    task automatic predict_pixel(input t_pixel_row r, output t_result res);
        logic [63:0] w;
        bit ok;
        logic signed [31:0] iv, rv, b;
        longint ab;
        w = shadow_reg[REG_WINDOW];
        if (r.start) clear_stats();
        ok = r.x >= w[15:0] && r.x <= w[31:16] && r.y >= w[47:32] && r.y <= w[63:48]
            && r.in_s >= $signed(shadow_reg[REG_IN_VALID][15:0])
            && r.in_s <= $signed(shadow_reg[REG_IN_VALID][31:16])
            && r.ref_s >= $signed(shadow_reg[REG_REF_VALID][15:0])
            && r.ref_s <= $signed(shadow_reg[REG_REF_VALID][31:16])
            && mask_passes(shadow_reg[REG_MASK_A], r.ma)
            && mask_passes(shadow_reg[REG_MASK_B], r.mb);
        res.bias_out = shadow_reg[REG_FILL][31:0];
        if (ok) begin
            iv = scaled(shadow_reg[REG_IN_GO], r.in_s);
            rv = scaled(shadow_reg[REG_REF_GO], r.ref_s);
            b  = clamp32(longint'(iv) - longint'(rv));
            ab = (b < 0) ? -longint'(b) : longint'(b);
            res.bias_out = b;
            if (st_count != 32'hFFFF_FFFF) st_count = st_count + 1;
            st_bias  = acc_signed(st_bias, longint'(b));
            st_abs   = acc_unsigned(st_abs, ab[62:0]);
            st_sq    = acc_unsigned(st_sq, 63'(ab * ab));
            st_in    = acc_signed(st_in, longint'(iv));
            st_ref   = acc_signed(st_ref, longint'(rv));
            st_cross = acc_signed(st_cross, longint'(iv) * longint'(rv));
            st_in_sq = acc_unsigned(st_in_sq, 63'(longint'(iv) * longint'(iv)));
            if (b < st_low) st_low = b;
            if (b > st_high) st_high = b;
        end
        res.matched        = ok;
        res.match_total    = st_count;
        res.bias_total     = st_bias;
        res.abs_bias_total = st_abs;
        res.sq_bias_total  = st_sq;
        res.in_total       = st_in;
        res.ref_total      = st_ref;
        res.cross_total    = st_cross;
        res.in_sq_total    = st_in_sq;
        res.bias_lowest    = st_low;
        res.bias_highest   = st_high;
    endtask

    task automatic report_mismatch(string field, logic [63:0] seen, logic [63:0] want);
        $display("mismatch %s: got %h expected %h (cycle %0d)", field, seen, want, cycles);
        fail_count++;
    endtask

    task automatic compare_result(t_result r, t_result e);
        if (r.bias_out !== e.bias_out) report_mismatch("bias_out", r.bias_out, e.bias_out);
        if (r.matched !== e.matched) report_mismatch("matched", r.matched, e.matched);
        if (r.match_total !== e.match_total)
            report_mismatch("match_total", r.match_total, e.match_total);
        if (r.bias_total !== e.bias_total)
            report_mismatch("bias_total", r.bias_total, e.bias_total);
        if (r.abs_bias_total !== e.abs_bias_total)
            report_mismatch("abs_bias_total", r.abs_bias_total, e.abs_bias_total);
        if (r.sq_bias_total !== e.sq_bias_total)
            report_mismatch("sq_bias_total", r.sq_bias_total, e.sq_bias_total);
        if (r.in_total !== e.in_total) report_mismatch("in_total", r.in_total, e.in_total);
        if (r.ref_total !== e.ref_total) report_mismatch("ref_total", r.ref_total, e.ref_total);
        if (r.cross_total !== e.cross_total)
            report_mismatch("cross_total", r.cross_total, e.cross_total);
        if (r.in_sq_total !== e.in_sq_total)
            report_mismatch("in_sq_total", r.in_sq_total, e.in_sq_total);
        if (r.bias_lowest !== e.bias_lowest)
            report_mismatch("bias_lowest", r.bias_lowest, e.bias_lowest);
        if (r.bias_highest !== e.bias_highest)
            report_mismatch("bias_highest", r.bias_highest, e.bias_highest);
    endtask

    // result side: check each transfer, then decide the next pop
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else begin
            if (i_pop && !o_empty) begin
                if (predicted_stats.size() == 0) begin
                    $display("unexpected result transfer (cycle %0d)", cycles);
                    fail_count++;
                end else begin
                    compare_result(got, predicted_stats.pop_front());
                end
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                i_pop <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 0;
                rx_hold_left = LONG_HOLD;
                i_pop <= 1'b0;
            end else if ($urandom_range(99) < rx_stall_pct) begin
                rx_hold_left = ($urandom_range(19) == 0) ? $urandom_range(80, 25)
                                                         : $urandom_range(3, 0);
                i_pop <= 1'b0;
            end else begin
                i_pop <= 1'b1;
            end
        end
    end

    task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        for (int i = 0; i < 8; i++)
            if (idx == REG_ID[i]) shadow_reg[i] = data & REG_KEEP[i];
    endtask

    task automatic load_cfg();
        for (int i = 0; i < 8; i++) cfg_write(REG_ID[i], next_cfg[i]);
        cfg_write(REG_NONE, {$urandom, $urandom});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (predicted_stats.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_pixel(input t_pixel_row r);
        int gap;
        t_result e;
        gap = 0;
        if (!tx_no_gaps) begin
            case ($urandom_range(49))
                0:       gap = $urandom_range(60, 20);
                1, 2, 3: gap = $urandom_range(10, 4);
                default: gap = ($urandom_range(9) < 3) ? $urandom_range(3, 1) : 0;
            endcase
        end
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_push          <= 1'b1;
        i_pixel_x       <= r.x;
        i_pixel_y       <= r.y;
        i_in_sample     <= r.in_s;
        i_ref_sample    <= r.ref_s;
        i_mask_a_sample <= r.ma;
        i_mask_b_sample <= r.mb;
        i_start_image   <= r.start;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        predict_pixel(r, e);
        if (r.fixed) e = r.fixed_res;
        predicted_stats = {predicted_stats, e};
    endtask

    // directed settings: each compare operator on both masks, then saturating gains
    task automatic set_directed_cfg(int p);
        logic [2:0] op;
        next_cfg[0] = 64'h7FFF_8000;
        next_cfg[1] = 64'h7FFF_8000;
        next_cfg[2] = 64'd4096;
        next_cfg[3] = 64'd4096;
        next_cfg[4] = 64'hFFFF_0000_FFFF_0000;
        next_cfg[7] = 64'h1234_5678;
        op = 3'(p - 1);
        next_cfg[5] = {44'd0, 16'sd5, op, 1'b1};
        next_cfg[6] = {44'd0, -16'sd5, 3'(7 - op), 1'b1};
        if (p == 9) begin
            next_cfg[2] = {16'd0, 32'h7FFF_FFFF, 16'h7FFF};
            next_cfg[3] = {16'd0, 32'h8000_0000, 16'h8000};
            next_cfg[5] = 64'd0;
            next_cfg[6] = 64'd0;
        end
    endtask

    task automatic set_random_cfg(int k);
        logic [15:0] xf, xl, yf, yl;
        int lo, hi;
        if (k == 0) begin
            next_cfg = '{64'h7FFF_8000, 64'h7FFF_8000, {16'd0, 32'h7FFF_FFFF, 16'h7FFF},
                         {16'd0, 32'h8000_0000, 16'h8000}, 64'hFFFF_0000_FFFF_0000,
                         64'd0, 64'd0, 64'h7FFF_FFFF};
        end else if (k == 1) begin
            next_cfg = '{64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'hF_FFFF, 64'hF_FFFF,
                         64'h8000_0000};
        end else begin
            xf = 16'($urandom_range(65535 - 64));
            xl = ($urandom_range(9) == 0) ? 16'(xf - 16'd1)
                                          : 16'(xf + 16'($urandom_range(63)));
            yf = 16'($urandom_range(65535 - 64));
            yl = 16'(yf + 16'($urandom_range(63)));
            next_cfg[4] = {yl, yf, xl, xf};
            for (int i = 0; i < 2; i++) begin
                lo = -int'($urandom_range(32768));
                hi = $urandom_range(32767);
                next_cfg[i] = ($urandom_range(9) == 0) ? {32'd0, $urandom}
                                                       : {32'd0, 16'(hi), 16'(lo)};
            end
            for (int i = 2; i < 4; i++)
                next_cfg[i] = $urandom_range(1) ? {16'd0, $urandom, 16'(int'($urandom))}
                    : {16'd0, 32'($urandom_range(8191)) - 32'd4096,
                       16'($urandom_range(8192, 2048))};
            next_cfg[5] = {44'd0, 20'($urandom)};
            next_cfg[6] = {44'd0, 20'($urandom)};
            next_cfg[7] = {32'd0, $urandom};
        end
    endtask

    function automatic logic [15:0] pick_in_range(logic [15:0] a, logic [15:0] b);
        if (a > b || $urandom_range(9) < 2) return 16'($urandom);
        return a + 16'($urandom_range(int'(b - a)));
    endfunction

    function automatic logic signed [15:0] pick_sample(logic [31:0] bounds);
        int lo, hi;
        lo = $signed(bounds[15:0]);
        hi = $signed(bounds[31:16]);
        if (lo > hi || $urandom_range(9) < 2) return 16'($urandom);
        return 16'(lo + int'($urandom_range(hi - lo)));
    endfunction

    task automatic make_random_pixel(output t_pixel_row r);
        r.x     = pick_in_range(shadow_reg[REG_WINDOW][15:0], shadow_reg[REG_WINDOW][31:16]);
        r.y     = pick_in_range(shadow_reg[REG_WINDOW][47:32], shadow_reg[REG_WINDOW][63:48]);
        r.in_s  = pick_sample(shadow_reg[REG_IN_VALID][31:0]);
        r.ref_s = pick_sample(shadow_reg[REG_REF_VALID][31:0]);
        r.ma    = 16'($urandom);
        r.mb    = 16'($urandom);
        r.start = ($urandom_range(59) == 0);
        r.phase = 0;
        r.fixed = 0;
        r.fixed_res = IDLE_RESULT;
    endtask

    initial begin
        t_pixel_row r;
        int cur_phase;
        i_rst_n         <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= '0;
        i_cfg_data      <= '0;
        i_push          <= 1'b0;
        i_pixel_x       <= '0;
        i_pixel_y       <= '0;
        i_in_sample     <= '0;
        i_ref_sample    <= '0;
        i_mask_a_sample <= '0;
        i_mask_b_sample <= '0;
        i_start_image   <= 1'b0;
        shadow_reg = '{64'h7FFF_8000, 64'h7FFF_8000, 64'd4096, 64'd4096,
                       64'hFFFF_FFFF_0000_FFFF, 64'd0, 64'd0, 64'd0};
        clear_stats();

        // reset window matches nothing, so these results are known outright
        add_row('{16'h0000, 16'h0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
                  1'b0, 0, 1'b1, IDLE_RESULT});
        add_row('{16'hFFFF, 16'hFFFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                  1'b1, 0, 1'b1, IDLE_RESULT});
        add_row('{16'h0000, 16'hFFFF, -16'sh8000, -16'sh8000, -16'sh8000,
                  -16'sh8000, 1'b0, 0, 1'b1, IDLE_RESULT});
        for (int p = 1; p <= 8; p++) begin
            add_row('{16'd5, 16'd9, 16'sd100, -16'sd100, 16'sd5, -16'sd5,
                      1'b0, p, 1'b0, IDLE_RESULT});
            add_row('{16'd7, 16'd3, -16'sd300, 16'sd40, 16'sd4, -16'sd4,
                      1'b0, p, 1'b0, IDLE_RESULT});
        end
        add_row('{16'd1, 16'd1, 16'sh7FFF, -16'sh8000, 16'sd0, 16'sd0,
                  1'b1, 9, 1'b0, IDLE_RESULT});
        add_row('{16'd2, 16'd2, -16'sh8000, 16'sh7FFF, 16'sd0, 16'sd0,
                  1'b0, 9, 1'b0, IDLE_RESULT});
        add_row('{16'hFFFF, 16'h0000, 16'sh7FFF, 16'sh7FFF, 16'sd0, 16'sd0,
                  1'b0, 9, 1'b0, IDLE_RESULT});
        add_row('{16'h8000, 16'h8000, -16'sh8000, -16'sh8000, 16'sd0, 16'sd0,
                  1'b0, 9, 1'b0, IDLE_RESULT});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cur_phase = 0;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].phase != cur_phase) begin
                i_push <= 1'b0;
                wait_drained();
                cur_phase = dir_rows[i].phase;
                set_directed_cfg(cur_phase);
                load_cfg();
            end
            send_pixel(dir_rows[i]);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            i_push <= 1'b0;
            wait_drained();
            set_random_cfg(ph);
            load_cfg();
            tx_no_gaps   = ($urandom_range(3) == 0);
            rx_stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(40, 5);
            // receiver stops for a long stretch while pixels keep coming
            if (ph == HOLD_PHASE) long_hold_req = 1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                make_random_pixel(r);
                send_pixel(r);
            end
        end
        i_push <= 1'b0;
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && predicted_stats.size() == 0) begin
            $display("** masked_pixel_bias_stats: PASSED **");
        end else begin
            $display("** masked_pixel_bias_stats: FAILED **");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/mpbs_pkg.sv
rtl/core/mpbs_fifo.sv
rtl/core/mpbs_front.sv
rtl/core/mpbs_back.sv
rtl/core/masked_pixel_bias_stats.sv
rtl/core/mpbs_checker.sv
tb/masked_pixel_bias_stats_test.sv
